// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// A condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

// ===== sv/otsc_pkg.sv =====
// Types and constants shared by the tuning sweep calibrator modules.
package otsc_pkg;

  localparam int TuneStepsDef = 16;

  localparam int SettingW = 4;
  localparam int CountW   = 16;
  localparam int TickW    = 24;
  localparam int SettleW  = 20;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 24;

  localparam logic [CountW-1:0]  TargetRst = 16'd3125;
  localparam logic [TickW-1:0]   WindowRst = 24'd100000;
  localparam logic [SettleW-1:0] SettleRst = 20'd2000;
  localparam logic [CountW-1:0]  MaxErrRst = 16'd109;
  localparam logic [CountW-1:0]  CountMax  = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgTarget = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgWindow = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgSettle = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxErr = 8'd3;

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhSettle = 2'd1,
    PhCount  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CountW-1:0]  target_count;
    logic [TickW-1:0]   window_ticks;
    logic [SettleW-1:0] settle_ticks;
    logic [CountW-1:0]  max_error;
  } cfg_t;

  typedef struct packed {
    logic [SettingW-1:0] tune_setting;
    logic                show_oscillator;
    logic                busy_res;
    logic                done_res;
    logic                rco_request;
    logic                passed;
    logic [CountW-1:0]   best_error;
  } result_t;

endpackage

// ===== sv/oscillator_tune_sweep_calibrator.sv =====
// A word's result is written to the output buffer at the edge that accepts it.
// One word per cycle unless the buffer is full; the state advances in one pass.
// A two-word output buffer lets input be taken while a result waits downstream.
// Reset (rst_ni low, asynchronous) idles the sweep, clears the buffer and
// restores the configuration registers to their default values.
module oscillator_tune_sweep_calibrator #(
  parameter int TuneSteps = otsc_pkg::TuneStepsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [otsc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [otsc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic                              pin_level_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [otsc_pkg::SettingW-1:0]     tune_setting_o,
  output logic                              show_oscillator_o,
  output logic                              busy_res_o,
  output logic                              done_res_o,
  output logic                              rco_request_o,
  output logic                              passed_o,
  output logic [otsc_pkg::CountW-1:0]       best_error_o
);

  // Configuration registers. Writes are only expected while the block is
  // idle, so they are taken directly with no interlock against the sweep.
  otsc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_count <= otsc_pkg::TargetRst;
      cfg_q.window_ticks <= otsc_pkg::WindowRst;
      cfg_q.settle_ticks <= otsc_pkg::SettleRst;
      cfg_q.max_error    <= otsc_pkg::MaxErrRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        otsc_pkg::CfgTarget: cfg_q.target_count <= cfg_data_i[otsc_pkg::CountW-1:0];
        otsc_pkg::CfgWindow: cfg_q.window_ticks <= cfg_data_i[otsc_pkg::TickW-1:0];
        otsc_pkg::CfgSettle: cfg_q.settle_ticks <= cfg_data_i[otsc_pkg::SettleW-1:0];
        otsc_pkg::CfgMaxErr: cfg_q.max_error    <= cfg_data_i[otsc_pkg::CountW-1:0];
        default: begin
          // Writes to indexes beyond the register list are dropped.
        end
      endcase
    end
  end

  // An input word is taken whenever the output buffer has a free slot. The
  // stall is driven straight from the buffer fill, so it never depends
  // combinationally on the downstream stall.
  logic push, pop;
  assign push = in_valid_i & ~in_stall_o;
  assign pop  = out_valid_o & ~out_stall_i;

  // The core updates its sweep state on each accepted word and presents the
  // result of that word combinationally, ready to be written to the buffer.
  otsc_pkg::result_t res;

  otsc_core #(
    .TuneSteps (TuneSteps)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (push),
    .action_i    (action_i),
    .pin_level_i (pin_level_i),
    .cfg_i       (cfg_q),
    .res_o       (res)
  );

  // Two-entry result buffer. Holding two words means a full slot waiting on
  // the downstream side does not stop the next sample tick from being taken.
  otsc_pkg::result_t buf_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q, count_d;

  always_comb begin
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);

  assign tune_setting_o    = buf_q[rd_ptr_q].tune_setting;
  assign show_oscillator_o = buf_q[rd_ptr_q].show_oscillator;
  assign busy_res_o        = buf_q[rd_ptr_q].busy_res;
  assign done_res_o        = buf_q[rd_ptr_q].done_res;
  assign rco_request_o     = buf_q[rd_ptr_q].rco_request;
  assign passed_o          = buf_q[rd_ptr_q].passed;
  assign best_error_o      = buf_q[rd_ptr_q].best_error;

endmodule

// ===== sv/otsc_core.sv =====
// Sweep state machine: settle and count per setting, keeping the best one.
module otsc_core #(
  parameter int TuneSteps = otsc_pkg::TuneStepsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             action_i,
  input  logic             pin_level_i,
  input  otsc_pkg::cfg_t   cfg_i,
  output otsc_pkg::result_t res_o
);

  localparam logic [otsc_pkg::SettingW-1:0] LastIdx = otsc_pkg::SettingW'(TuneSteps - 1);

  otsc_pkg::phase_e                phase_q, phase_d;
  logic [otsc_pkg::SettingW-1:0]   idx_q, idx_d;
  logic [otsc_pkg::TickW-1:0]      tick_q, tick_d, tick_inc, win;
  logic [otsc_pkg::CountW-1:0]     edge_q, edge_d, edge_new, diff;
  logic                            prev_q, prev_d;
  logic [otsc_pkg::CountW-1:0]     best_q, best_d;
  logic [otsc_pkg::SettingW-1:0]   bset_q, bset_d;
  logic                            pass_q, pass_d;
  logic                            done, busy;

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    tick_d   = tick_q;
    edge_d   = edge_q;
    prev_d   = prev_q;
    best_d   = best_q;
    bset_d   = bset_q;
    pass_d   = pass_q;
    done     = 1'b0;
    tick_inc = tick_q + 1'b1;
    win      = (cfg_i.window_ticks == '0) ? otsc_pkg::TickW'(1) : cfg_i.window_ticks;
    edge_new = edge_q;
    if ((tick_q != '0) && pin_level_i && !prev_q && (edge_q != otsc_pkg::CountMax)) begin
      edge_new = edge_q + 1'b1;
    end
    diff = (cfg_i.target_count >= edge_new) ? cfg_i.target_count - edge_new
                                            : edge_new - cfg_i.target_count;
    if (action_i) begin
      phase_d = otsc_pkg::PhSettle;
      idx_d   = '0;
      tick_d  = '0;
      edge_d  = '0;
      best_d  = otsc_pkg::CountMax;
      bset_d  = '0;
      pass_d  = 1'b0;
    end else begin
      case (phase_q)
        otsc_pkg::PhSettle: begin
          if (tick_inc >= {4'b0, cfg_i.settle_ticks}) begin
            phase_d = otsc_pkg::PhCount;
            tick_d  = '0;
            edge_d  = '0;
          end else begin
            tick_d = tick_inc;
          end
        end
        otsc_pkg::PhCount: begin
          prev_d = pin_level_i;
          edge_d = edge_new;
          tick_d = tick_inc;
          if (tick_inc >= win) begin
            if (diff < best_q) begin
              best_d = diff;
              bset_d = idx_q;
            end
            tick_d = '0;
            edge_d = '0;
            if (idx_q >= LastIdx) begin
              phase_d = otsc_pkg::PhIdle;
              pass_d  = (best_d <= cfg_i.max_error);
              done    = 1'b1;
            end else begin
              idx_d   = idx_q + 1'b1;
              phase_d = otsc_pkg::PhSettle;
            end
          end
        end
        default: begin
          phase_d = otsc_pkg::PhIdle;
        end
      endcase
    end

    busy = (phase_d == otsc_pkg::PhSettle) || (phase_d == otsc_pkg::PhCount);
    res_o.tune_setting    = busy ? idx_d : bset_d;
    res_o.show_oscillator = busy;
    res_o.busy_res        = busy;
    res_o.done_res        = done;
    res_o.rco_request     = done;
    res_o.passed          = pass_d;
    res_o.best_error      = best_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= otsc_pkg::PhIdle;
      idx_q   <= '0;
      tick_q  <= '0;
      edge_q  <= '0;
      prev_q  <= 1'b0;
      best_q  <= otsc_pkg::CountMax;
      bset_q  <= '0;
      pass_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      tick_q  <= tick_d;
      edge_q  <= edge_d;
      prev_q  <= prev_d;
      best_q  <= best_d;
      bset_q  <= bset_d;
      pass_q  <= pass_d;
    end
  end

endmodule

// ===== sv/otsc_checker.sv =====
// Port-level checker for the tuning sweep calibrator, bound to the top level.
`include "assert_macros.svh"

module otsc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic show_oscillator_o,
  input logic busy_res_o,
  input logic done_res_o,
  input logic rco_request_o
);

  // A finishing word reports the sweep as no longer running.
  `ASSERT_ALWAYS(a_done_not_busy, !(out_valid_o && done_res_o && busy_res_o))
  // The calibrate request is issued exactly on the finishing word.
  `ASSERT_ALWAYS(a_rco_with_done, !out_valid_o || (rco_request_o == done_res_o))
  // The oscillator is routed to the pin for exactly as long as a sweep runs.
  `ASSERT_ALWAYS(a_show_busy, !out_valid_o || (show_oscillator_o == busy_res_o))
  // Input is held off only when results are already waiting.
  `ASSERT_ALWAYS(a_stall_has_data, !in_stall_o || out_valid_o)
  // A result that is not taken stays offered.
  `ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o)

endmodule

bind oscillator_tune_sweep_calibrator otsc_checker u_otsc_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the tuning-capacitor sweep calibrator.
`timescale 1ns / 100ps

module testbench;
  import otsc_pkg::*;

  localparam int TuneSteps     = TuneStepsDef;
  localparam int ClkHalf       = 5;
  localparam int ResetCycles   = 9;
  localparam int IdlePercent   = 22;
  localparam int RandomWords   = 1200;
  localparam int HoldOffCycles = 80;
  localparam int DrainCycles   = 3;
  localparam int QuietLimit    = 2000;

  // A counting window far longer than the random sweeps use, still short enough to keep
  // the run to a modest number of words.
  localparam logic [TickW-1:0] LongWindow = 24'd100;

  // Register indexes that lie beyond the register file and must be ignored.
  localparam logic [CfgIdxW-1:0] CfgUnused = CfgMaxErr + 1'b1;
  localparam logic [CfgIdxW-1:0] CfgIdxTop = '1;

  typedef enum logic {
    RowWord,
    RowReg
  } row_kind_e;

  // One line of the directed table: either an input word or a register write.
  typedef struct packed {
    row_kind_e            kind;
    logic                 act;
    logic                 pin;
    logic                 known;
    result_t              want;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
  } stim_row_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  // Status words that can be read straight off the behaviour without prediction.
  localparam result_t IdleAfterReset = '{4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, CountMax};
  localparam result_t FreshSweep     = '{4'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, CountMax};

  // The directed part. The first rows run on the reset configuration, where the
  // status is obvious; the rest use a tiny window and are checked by prediction.
  localparam stim_row_t DirectedRows [18] = '{
    '{RowWord, 1'b0, 1'b0, 1'b1, IdleAfterReset, CfgTarget, 24'd0},
    '{RowWord, 1'b0, 1'b1, 1'b1, IdleAfterReset, CfgTarget, 24'd0},
    '{RowWord, 1'b1, 1'b1, 1'b1, FreshSweep,     CfgTarget, 24'd0},
    '{RowWord, 1'b0, 1'b1, 1'b1, FreshSweep,     CfgTarget, 24'd0},
    '{RowWord, 1'b1, 1'b0, 1'b1, FreshSweep,     CfgTarget, 24'd0},
    '{RowReg,  1'b0, 1'b0, 1'b0, '0,             CfgTarget, 24'd1},
    '{RowReg,  1'b0, 1'b0, 1'b0, '0,             CfgWindow, 24'd2},
    '{RowReg,  1'b0, 1'b0, 1'b0, '0,             CfgSettle, 24'd0},
    '{RowReg,  1'b0, 1'b0, 1'b0, '0,             CfgMaxErr, 24'd0},
    '{RowWord, 1'b1, 1'b0, 1'b0, '0,             CfgTarget, 24'd0},
    '{RowWord, 1'b0, 1'b1, 1'b0, '0,             CfgTarget, 24'd0},
    '{RowWord, 1'b0, 1'b0, 1'b0, '0,             CfgTarget, 24'd0},
    '{RowWord, 1'b0, 1'b1, 1'b0, '0,             CfgTarget, 24'd0},
    '{RowWord, 1'b0, 1'b0, 1'b0, '0,             CfgTarget, 24'd0},
    '{RowWord, 1'b0, 1'b1, 1'b0, '0,             CfgTarget, 24'd0},
    '{RowWord, 1'b0, 1'b0, 1'b0, '0,             CfgTarget, 24'd0},
    '{RowWord, 1'b1, 1'b1, 1'b0, '0,             CfgTarget, 24'd0},
    '{RowWord, 1'b0, 1'b0, 1'b0, '0,             CfgTarget, 24'd0}
  };

  // Every input of the block starts from a known value.
  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;
  logic                in_valid    = 1'b0;
  logic                action      = 1'b0;
  logic                pin_level   = 1'b0;
  logic                out_stall   = 1'b0;

  logic                in_stall;
  logic                out_valid;
  logic [SettingW-1:0] tune_setting;
  logic                show_oscillator;
  logic                busy_res;
  logic                done_res;
  logic                rco_request;
  logic                passed;
  logic [CountW-1:0]   best_error;

  // Own copy of the calibrator state and its registers, at reset values.
  cfg_t cfg_shadow = '{TargetRst, WindowRst, SettleRst, MaxErrRst};

  phase_e              cal_phase        = PhIdle;
  logic [SettingW-1:0] cal_setting      = '0;
  logic [TickW-1:0]    cal_ticks        = '0;
  logic [CountW-1:0]   cal_edges        = '0;
  logic                cal_prev_pin     = 1'b0;
  logic [CountW-1:0]   cal_best_diff    = CountMax;
  logic [SettingW-1:0] cal_best_setting = '0;
  logic                cal_pass         = 1'b0;

  result_t    awaited_status[$];
  reg_write_t pending_writes[$];

  int  mismatch_count = 0;
  int  words_sent     = 0;
  int  quiet_cycles   = 0;
  int  hold_request   = 0;
  int  hold_left      = 0;
  // While steady is set neither side idles nor stalls at random.
  bit  steady         = 1'b0;

  oscillator_tune_sweep_calibrator i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .action_i          (action),
    .pin_level_i       (pin_level),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .tune_setting_o    (tune_setting),
    .show_oscillator_o (show_oscillator),
    .busy_res_o        (busy_res),
    .done_res_o        (done_res),
    .rco_request_o     (rco_request),
    .passed_o          (passed),
    .best_error_o      (best_error)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // Advances the predicted sweep by one sample tick and returns the status word
  // that the block should report afterwards.
  function automatic result_t next_sweep_status(input logic act, input logic pin);
    result_t          status;
    logic [TickW-1:0] window;
    logic [CountW-1:0] diff;
    logic             finished;
    logic             busy;
    finished = 1'b0;
    if (act) begin
      // A start always begins afresh, even in the middle of a sweep.
      cal_phase        = PhSettle;
      cal_setting      = '0;
      cal_ticks        = '0;
      cal_edges        = '0;
      cal_best_diff    = CountMax;
      cal_best_setting = '0;
      cal_pass         = 1'b0;
    end else if (cal_phase == PhSettle) begin
      // Settling takes at least one tick, even with a zero settle time.
      cal_ticks = cal_ticks + 1'b1;
      if (cal_ticks >= cfg_shadow.settle_ticks) begin
        cal_phase = PhCount;
        cal_ticks = '0;
        cal_edges = '0;
      end
    end else if (cal_phase == PhCount) begin
      window = (cfg_shadow.window_ticks == '0) ? TickW'(1) : cfg_shadow.window_ticks;
      // The first sample of a window only seeds the previous level.
      if (cal_ticks != '0 && pin && !cal_prev_pin && cal_edges != CountMax) begin
        cal_edges = cal_edges + 1'b1;
      end
      cal_prev_pin = pin;
      cal_ticks    = cal_ticks + 1'b1;
      if (cal_ticks >= window) begin
        diff = (cfg_shadow.target_count >= cal_edges) ?
               cfg_shadow.target_count - cal_edges : cal_edges - cfg_shadow.target_count;
        // Strictly smaller only, so the earliest setting keeps a tie.
        if (diff < cal_best_diff) begin
          cal_best_diff    = diff;
          cal_best_setting = cal_setting;
        end
        cal_ticks = '0;
        cal_edges = '0;
        if (cal_setting >= TuneSteps - 1) begin
          cal_phase = PhIdle;
          cal_pass  = (cal_best_diff <= cfg_shadow.max_error);
          finished  = 1'b1;
        end else begin
          cal_setting = cal_setting + 1'b1;
          cal_phase   = PhSettle;
        end
      end
    end else begin
      cal_phase = PhIdle;
    end
    busy = (cal_phase == PhSettle) || (cal_phase == PhCount);
    status.tune_setting    = busy ? cal_setting : cal_best_setting;
    status.show_oscillator = busy;
    status.busy_res        = busy;
    status.done_res        = finished;
    status.rco_request     = finished;
    status.passed          = cal_pass;
    status.best_error      = cal_best_diff;
    return status;
  endfunction

  // Offers one word, waits until it is taken and records what it should produce.
  // Where a typed value is given it stands in for the prediction.
  task automatic send_word(input logic act, input logic pin,
                           input logic use_typed = 1'b0, input result_t typed = '0);
    result_t predicted;
    while (!steady && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    pin_level <= pin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = next_sweep_status(act, pin);
    awaited_status.push_back(use_typed ? typed : predicted);
    words_sent++;
  endtask

  // Stops offering words and lets every awaited status word come back, plus the
  // block's latency, so that nothing is still in flight.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic queue_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    pending_writes.push_back('{idx, data});
  endtask

  // Applies the queued register writes on an idle block, one per clock edge.
  task automatic program_registers();
    quiesce();
    foreach (pending_writes[w]) begin
      cfg_we    <= 1'b1;
      cfg_index <= pending_writes[w].idx;
      cfg_data  <= pending_writes[w].data;
      @(posedge clk);
      case (pending_writes[w].idx)
        CfgTarget: cfg_shadow.target_count = pending_writes[w].data[CountW-1:0];
        CfgWindow: cfg_shadow.window_ticks = pending_writes[w].data[TickW-1:0];
        CfgSettle: cfg_shadow.settle_ticks = pending_writes[w].data[SettleW-1:0];
        CfgMaxErr: cfg_shadow.max_error    = pending_writes[w].data[CountW-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
    pending_writes.delete();
  endtask

  // One well-formed sweep: a start, then ticks until the sweep completes. The
  // pin toggles with a period that depends on the setting under test, with a
  // little noise, so that counts differ from setting to setting and ties occur.
  task automatic run_sweep(input int restarts, input int skew);
    int   half;
    int   run;
    logic pin;
    pin = 1'b0;
    run = 0;
    send_word(1'b1, 1'($urandom_range(1)));
    while (cal_phase != PhIdle) begin
      half = 1 + ((int'(cal_setting) + skew) % 3);
      run  = run + 1;
      if (run >= half) begin
        pin = ~pin;
        run = 0;
      end
      if ($urandom_range(99) < 8) pin = 1'($urandom_range(1));
      if (restarts > 0 && $urandom_range(199) == 0) begin
        restarts--;
        send_word(1'b1, pin);
      end else begin
        send_word(1'b0, pin);
      end
    end
    // A few ticks on the idle block, which must leave the status untouched.
    repeat ($urandom_range(3)) send_word(1'b0, 1'($urandom_range(1)));
  endtask

  // Random register values for one sweep; the first two sweeps take the extremes.
  task automatic choose_sweep_settings(input int sweep);
    if (sweep == 0) begin
      // A one-tick window counts nothing, so a zero target is hit exactly.
      queue_write(CfgTarget, 24'd0);
      queue_write(CfgWindow, 24'd1);
      queue_write(CfgSettle, 24'd0);
      queue_write(CfgMaxErr, 24'd0);
    end else if (sweep == 1) begin
      // The error never drops below all ones, yet the widest limit still passes.
      queue_write(CfgTarget, CfgDataW'(CountMax));
      queue_write(CfgWindow, 24'd0);
      queue_write(CfgSettle, 24'd3);
      queue_write(CfgMaxErr, CfgDataW'(CountMax));
    end else begin
      queue_write(CfgTarget, ($urandom_range(9) == 0) ?
                  CfgDataW'($urandom_range(65535)) : CfgDataW'($urandom_range(12)));
      queue_write(CfgWindow, ($urandom_range(9) == 0) ?
                  24'd0 : CfgDataW'($urandom_range(10, 1)));
      queue_write(CfgSettle, CfgDataW'($urandom_range(4)));
      queue_write(CfgMaxErr, ($urandom_range(9) == 0) ?
                  CfgDataW'($urandom_range(65535)) : CfgDataW'($urandom_range(4)));
    end
    program_registers();
  endtask

  // An alternating pin over a longer window against a target of all ones, so the
  // count builds up well past the small values of the random sweeps.
  task automatic run_long_window();
    logic pin;
    queue_write(CfgTarget, CfgDataW'(CountMax));
    queue_write(CfgWindow, CfgDataW'(LongWindow));
    queue_write(CfgSettle, 24'd0);
    queue_write(CfgMaxErr, 24'd0);
    program_registers();
    steady = 1'b1;
    pin    = 1'b0;
    send_word(1'b1, pin);
    while (cal_setting == '0 && cal_phase != PhIdle) begin
      pin = ~pin;
      send_word(1'b0, pin);
    end
    repeat (4) send_word(1'b0, 1'b1);
    // Restart in the middle of the sweep and let it settle briefly.
    send_word(1'b1, 1'b0);
    repeat (4) send_word(1'b0, 1'b1);
    steady = 1'b0;
  endtask

  // Widest window and settle time, with the data bits above each narrower register set
  // and writes to indexes outside the register file. Only a short stretch is run.
  task automatic run_extreme_settings();
    queue_write(CfgTarget, {8'hA5, CountMax});
    queue_write(CfgWindow, '1);
    queue_write(CfgSettle, '1);
    queue_write(CfgMaxErr, {8'h5A, CountMax});
    queue_write(CfgUnused, CfgDataW'($urandom_range(65535)));
    queue_write(CfgIdxTop, CfgDataW'($urandom_range(65535)));
    program_registers();
    send_word(1'b1, 1'b1);
    repeat (40) send_word(1'b0, 1'($urandom_range(1)));
  endtask

  // Stimulus: reset, the directed table, random sweeps, then the long-window and
  // extreme-register cases.
  initial begin
    int random_start;
    int sweep;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedRows[r]) begin
      if (DirectedRows[r].kind == RowReg) begin
        queue_write(DirectedRows[r].idx, DirectedRows[r].data);
      end else begin
        if (pending_writes.size() != 0) program_registers();
        send_word(DirectedRows[r].act, DirectedRows[r].pin,
                  DirectedRows[r].known, DirectedRows[r].want);
      end
    end

    random_start = words_sent;
    sweep        = 0;
    while (words_sent - random_start < RandomWords) begin
      // Registers change only once the block has handed back every status word.
      choose_sweep_settings(sweep);
      // Two sweeps run with neither side idling.
      steady = (sweep == 4) || (sweep == 5);
      // Once, the receiver holds off long enough for the block to back up.
      if (sweep == 2) hold_request = HoldOffCycles;
      // Now and then a burst of noise, which may leave a sweep half done.
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(20, 5)) begin
          send_word(1'($urandom_range(9) == 0), 1'($urandom_range(1)));
        end
      end
      run_sweep($urandom_range(1), $urandom_range(2));
      sweep++;
    end
    steady = 1'b0;

    run_long_window();
    run_extreme_settings();

    quiesce();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  task automatic check_field(input string label, input logic [CountW-1:0] want,
                             input logic [CountW-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  // Receiver: takes status words when not stalled and checks each one against
  // the oldest awaited word, then decides whether to stall on the next cycle.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{tune_setting, show_oscillator, busy_res, done_res, rco_request, passed,
              best_error};
      if (awaited_status.size() == 0) begin
        mismatch_count++;
        $display("%0t: status word with none awaited, got %h", $time, got);
      end else begin
        want = awaited_status.pop_front();
        check_field("tune_setting", CountW'(want.tune_setting), CountW'(got.tune_setting));
        check_field("show_oscillator", CountW'(want.show_oscillator),
                    CountW'(got.show_oscillator));
        check_field("busy_res", CountW'(want.busy_res), CountW'(got.busy_res));
        check_field("done_res", CountW'(want.done_res), CountW'(got.done_res));
        check_field("rco_request", CountW'(want.rco_request), CountW'(got.rco_request));
        check_field("passed", CountW'(want.passed), CountW'(got.passed));
        check_field("best_error", want.best_error, got.best_error);
      end
    end
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < IdlePercent);
    end
  end

  // Watchdog: a run that moves no word in either direction for too long has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
